// ===== src/cflr_pkg.sv =====
// shared constants and register codes for the cfl timestep reduction block
`timescale 1ns / 1ps

package cflr_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int GAMMA_W = 19;
    localparam int CFL_W   = 17;
    localparam int WIDTH_W = 31;
    localparam int DT_W    = 31;
    localparam int CELL_W  = 32;
    localparam int IDX_W   = 3;

    localparam logic [GAMMA_W-1:0] GAMMA_RST = 19'd91750;
    localparam logic [CFL_W-1:0]   CFL_RST   = 17'd32768;
    localparam logic [WIDTH_W-1:0] DX_RST    = 31'd65536;
    localparam logic [WIDTH_W-1:0] DY_RST    = 31'd65536;
    localparam logic [DT_W-1:0]    DTMAX_RST = 31'd65536;

    localparam logic [IDX_W-1:0] REG_GAMMA = 3'd0;
    localparam logic [IDX_W-1:0] REG_CFL   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DX    = 3'd2;
    localparam logic [IDX_W-1:0] REG_DY    = 3'd3;
    localparam logic [IDX_W-1:0] REG_DTMAX = 3'd4;

endpackage

// ===== src/cfl_timestep_reduction_top.sv =====
// cfl timestep reduction: serial multiplier, divider and square root under one sequencer
// a cell with nonpositive density skips the arithmetic; a last cell also computes
// the two cfl terms before the result is presented
// throughput: one cell at a time, set by the bit-serial divider (four divisions per cell,
// two more on a last cell) and the bit-serial multiplier (four per cell, two more on a last cell)
// reset: synchronous active-low aresetn restores register defaults, clears maxima and flag
`timescale 1ns / 1ps

module cfl_timestep_reduction_top #(
    parameter int FRAC_BITS = cflr_pkg::FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // density, momentum_x, momentum_y, total_energy from bit 0 up
    input  logic [127:0]                 s_tdata,
    input  logic                         s_tlast,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // timestep, zero pad bit
    output logic [31:0]                  m_tdata,
    // bad_cell_seen
    output logic                         m_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         cfg_wr_en,
    input  logic [cflr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [cflr_pkg::WIDTH_W-1:0] cfg_wdata
);
    import cflr_pkg::*;

    localparam logic [63:0] ONE    = 64'd1 << FRAC_BITS;
    localparam logic [63:0] A2_CAP = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
    localparam logic [63:0] SPD_CAP = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] DT_CAP  = 64'h0000_0000_7FFF_FFFF;

    typedef enum logic [2:0] {S_IDLE, S_RUN, S_MUL, S_DIV, S_SQRT} state_t;
    typedef enum logic [3:0] {
        ST_KX, ST_KY, ST_KDIV, ST_PRES, ST_A2, ST_A2DIV, ST_SQRT, ST_AU, ST_AV,
        ST_MAX, ST_TX_MUL, ST_TX_DIV, ST_TY_MUL, ST_TY_DIV, ST_DONE
    } step_t;

    state_t state_reg;
    step_t  step_reg;

    logic [GAMMA_W-1:0] gamma_reg;
    logic [CFL_W-1:0]   cfl_reg;
    logic [WIDTH_W-1:0] dx_reg, dy_reg, dtmax_reg;

    logic [31:0] max_x_reg, max_y_reg;
    logic        bad_reg;

    logic [31:0] rho_reg, amx_reg, amy_reg, energy_reg;
    logic        last_reg;
    logic [63:0] t1_reg, a_reg, au_reg;
    logic [DT_W-1:0] tx_reg;

    // shared serial units
    logic [63:0] acc_reg, mcand_reg;
    logic [31:0] mplier_reg;
    logic [63:0] rem_reg, num_reg, den_reg, quo_reg;
    logic [63:0] sn_reg, root_reg, sbit_reg;
    logic [5:0]  cnt_reg;

    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg, m_tvalid_reg;

    logic [64:0] div_trial;
    logic        div_ge;
    logic [63:0] sq_try;
    logic        sq_ge;
    logic signed [65:0] internal;
    logic        int_pos;
    logic [63:0] gm1;
    logic [63:0] quo_sat, a2_sat;
    logic [64:0] sx_sum, sy_sum;
    logic [31:0] sx, sy;
    logic [DT_W-1:0] ty, dt_a, dt_b;
    logic [31:0] in_rho, in_mx, in_my;
    logic        out_load;

    assign div_trial = {rem_reg, num_reg[63]};
    assign div_ge    = div_trial >= {1'b0, den_reg};
    assign sq_try    = root_reg + sbit_reg;
    assign sq_ge     = sn_reg >= sq_try;

    assign internal = $signed({{34{energy_reg[31]}}, energy_reg}) - $signed({2'b00, quo_reg});
    assign int_pos  = !internal[65] && (internal != '0);
    assign gm1      = ({45'd0, gamma_reg} >= ONE) ? ({45'd0, gamma_reg} - ONE) : 64'd0;

    assign quo_sat = (quo_reg > SPD_CAP) ? SPD_CAP : quo_reg;
    assign a2_sat  = (quo_reg > A2_CAP) ? A2_CAP : quo_reg;

    assign sx_sum = {1'b0, a_reg} + {1'b0, au_reg};
    assign sy_sum = {1'b0, a_reg} + {1'b0, quo_sat};
    assign sx = (sx_sum > {1'b0, SPD_CAP}) ? 32'hFFFF_FFFF : sx_sum[31:0];
    assign sy = (sy_sum > {1'b0, SPD_CAP}) ? 32'hFFFF_FFFF : sy_sum[31:0];

    assign ty   = (max_y_reg == '0) ? dtmax_reg
                : ((quo_reg > DT_CAP) ? DT_CAP[DT_W-1:0] : quo_reg[DT_W-1:0]);
    assign dt_a = (tx_reg < dtmax_reg) ? tx_reg : dtmax_reg;
    assign dt_b = (ty < dt_a) ? ty : dt_a;

    assign in_rho = s_tdata[31:0];
    assign in_mx  = s_tdata[63:32];
    assign in_my  = s_tdata[95:64];

    // result register loads once it is free or being emptied
    assign out_load = (state_reg == S_RUN) && (step_reg == ST_DONE)
                   && (!m_tvalid_reg || m_tready);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= ST_KX;
            gamma_reg    <= GAMMA_RST;
            cfl_reg      <= CFL_RST;
            dx_reg       <= DX_RST;
            dy_reg       <= DY_RST;
            dtmax_reg    <= DTMAX_RST;
            max_x_reg    <= '0;
            max_y_reg    <= '0;
            bad_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_GAMMA: gamma_reg <= cfg_wdata[GAMMA_W-1:0];
                    REG_CFL:   cfl_reg   <= cfg_wdata[CFL_W-1:0];
                    REG_DX:    dx_reg    <= cfg_wdata;
                    REG_DY:    dy_reg    <= cfg_wdata;
                    REG_DTMAX: dtmax_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && !out_load) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        rho_reg    <= in_rho;
                        amx_reg    <= in_mx[31] ? (32'd0 - in_mx) : in_mx;
                        amy_reg    <= in_my[31] ? (32'd0 - in_my) : in_my;
                        energy_reg <= s_tdata[127:96];
                        last_reg   <= s_tlast;
                        if (in_rho[31] || in_rho == '0) begin
                            bad_reg <= 1'b1;
                            if (s_tlast) begin
                                step_reg  <= ST_TX_MUL;
                                state_reg <= S_RUN;
                            end
                        end else begin
                            step_reg  <= ST_KX;
                            state_reg <= S_RUN;
                        end
                    end
                end

                S_RUN: begin
                    // each step takes the last unit result and starts the next operation
                    case (step_reg)
                        ST_KX: begin
                            acc_reg    <= '0;
                            mcand_reg  <= {32'd0, amx_reg};
                            mplier_reg <= amx_reg;
                            cnt_reg    <= 6'd31;
                            step_reg   <= ST_KY;
                            state_reg  <= S_MUL;
                        end
                        ST_KY: begin
                            t1_reg     <= acc_reg;
                            acc_reg    <= '0;
                            mcand_reg  <= {32'd0, amy_reg};
                            mplier_reg <= amy_reg;
                            cnt_reg    <= 6'd31;
                            step_reg   <= ST_KDIV;
                            state_reg  <= S_MUL;
                        end
                        ST_KDIV: begin
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            num_reg   <= t1_reg + acc_reg;
                            den_reg   <= {31'd0, rho_reg, 1'b0};
                            cnt_reg   <= 6'd63;
                            step_reg  <= ST_PRES;
                            state_reg <= S_DIV;
                        end
                        ST_PRES: begin
                            acc_reg    <= '0;
                            mcand_reg  <= int_pos ? internal[63:0] : 64'd0;
                            mplier_reg <= gm1[31:0];
                            cnt_reg    <= 6'd31;
                            step_reg   <= ST_A2;
                            state_reg  <= S_MUL;
                        end
                        ST_A2: begin
                            acc_reg    <= '0;
                            mcand_reg  <= acc_reg >> FRAC_BITS;
                            mplier_reg <= {13'd0, gamma_reg};
                            cnt_reg    <= 6'd31;
                            step_reg   <= ST_A2DIV;
                            state_reg  <= S_MUL;
                        end
                        ST_A2DIV: begin
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            num_reg   <= acc_reg;
                            den_reg   <= {32'd0, rho_reg};
                            cnt_reg   <= 6'd63;
                            step_reg  <= ST_SQRT;
                            state_reg <= S_DIV;
                        end
                        ST_SQRT: begin
                            sn_reg    <= a2_sat << FRAC_BITS;
                            root_reg  <= '0;
                            sbit_reg  <= 64'd1 << 62;
                            cnt_reg   <= 6'd31;
                            step_reg  <= ST_AU;
                            state_reg <= S_SQRT;
                        end
                        ST_AU: begin
                            a_reg     <= root_reg;
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            num_reg   <= {32'd0, amx_reg} << FRAC_BITS;
                            den_reg   <= {32'd0, rho_reg};
                            cnt_reg   <= 6'd63;
                            step_reg  <= ST_AV;
                            state_reg <= S_DIV;
                        end
                        ST_AV: begin
                            au_reg    <= quo_sat;
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            num_reg   <= {32'd0, amy_reg} << FRAC_BITS;
                            den_reg   <= {32'd0, rho_reg};
                            cnt_reg   <= 6'd63;
                            step_reg  <= ST_MAX;
                            state_reg <= S_DIV;
                        end
                        ST_MAX: begin
                            if (sx > max_x_reg) begin
                                max_x_reg <= sx;
                            end
                            if (sy > max_y_reg) begin
                                max_y_reg <= sy;
                            end
                            if (last_reg) begin
                                step_reg <= ST_TX_MUL;
                            end else begin
                                state_reg <= S_IDLE;
                            end
                        end
                        ST_TX_MUL: begin
                            acc_reg    <= '0;
                            mcand_reg  <= {33'd0, dx_reg};
                            mplier_reg <= {15'd0, cfl_reg};
                            cnt_reg    <= 6'd31;
                            step_reg   <= ST_TX_DIV;
                            state_reg  <= S_MUL;
                        end
                        ST_TX_DIV: begin
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            num_reg   <= acc_reg;
                            den_reg   <= {32'd0, max_x_reg};
                            cnt_reg   <= 6'd63;
                            step_reg  <= ST_TY_MUL;
                            state_reg <= S_DIV;
                        end
                        ST_TY_MUL: begin
                            // zero speed gives the upper bound
                            tx_reg <= (max_x_reg == '0) ? dtmax_reg
                                    : ((quo_reg > DT_CAP) ? DT_CAP[DT_W-1:0]
                                                          : quo_reg[DT_W-1:0]);
                            acc_reg    <= '0;
                            mcand_reg  <= {33'd0, dy_reg};
                            mplier_reg <= {15'd0, cfl_reg};
                            cnt_reg    <= 6'd31;
                            step_reg   <= ST_TY_DIV;
                            state_reg  <= S_MUL;
                        end
                        ST_TY_DIV: begin
                            rem_reg   <= '0;
                            quo_reg   <= '0;
                            num_reg   <= acc_reg;
                            den_reg   <= {32'd0, max_y_reg};
                            cnt_reg   <= 6'd63;
                            step_reg  <= ST_DONE;
                            state_reg <= S_DIV;
                        end
                        ST_DONE: begin
                            // hold until the output register is free
                            if (out_load) begin
                                m_tdata_reg  <= {1'b0, dt_b};
                                m_tuser_reg  <= bad_reg;
                                m_tvalid_reg <= 1'b1;
                                max_x_reg    <= '0;
                                max_y_reg    <= '0;
                                bad_reg      <= 1'b0;
                                state_reg    <= S_IDLE;
                            end
                        end
                        default: state_reg <= S_IDLE;
                    endcase
                end

                S_MUL: begin
                    if (mplier_reg[0]) begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_RUN;
                    end
                end

                S_DIV: begin
                    rem_reg <= div_ge ? (div_trial[63:0] - den_reg) : div_trial[63:0];
                    quo_reg <= {quo_reg[62:0], div_ge};
                    num_reg <= num_reg << 1;
                    cnt_reg <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_RUN;
                    end
                end

                S_SQRT: begin
                    if (sq_ge) begin
                        sn_reg   <= sn_reg - sq_try;
                        root_reg <= (root_reg >> 1) + sbit_reg;
                    end else begin
                        root_reg <= root_reg >> 1;
                    end
                    sbit_reg <= sbit_reg >> 2;
                    cnt_reg  <= cnt_reg - 6'd1;
                    if (cnt_reg == '0) begin
                        state_reg <= S_RUN;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== bench/tb.sv =====
// self-checking testbench for the cfl timestep reduction block
`timescale 1ns / 1ps

class cfl_timestep_board;
    localparam longint unsigned SPEED_CAP = 64'hFFFF_FFFF;
    localparam longint unsigned STEP_CAP  = 64'h7FFF_FFFF;
    localparam int FB = cflr_pkg::FRAC_BITS_DEF;

    longint unsigned gamma_q, cfl_q, dx_q, dy_q, dtmax_q;
    longint unsigned peak_sx, peak_sy;
    bit              bad_seen;
    bit [30:0]       step_q[$];
    bit              flag_q[$];
    int              errors;

    function new();
        restore();
        errors = 0;
    endfunction

    function void restore();
        gamma_q  = cflr_pkg::GAMMA_RST;
        cfl_q    = cflr_pkg::CFL_RST;
        dx_q     = cflr_pkg::DX_RST;
        dy_q     = cflr_pkg::DY_RST;
        dtmax_q  = cflr_pkg::DTMAX_RST;
        peak_sx  = 0;
        peak_sy  = 0;
        bad_seen = 0;
    endfunction

    function void write_reg(logic [cflr_pkg::IDX_W-1:0] idx, logic [30:0] val);
        case (idx)
            cflr_pkg::REG_GAMMA: gamma_q = val[18:0];
            cflr_pkg::REG_CFL:   cfl_q   = val[16:0];
            cflr_pkg::REG_DX:    dx_q    = val;
            cflr_pkg::REG_DY:    dy_q    = val;
            cflr_pkg::REG_DTMAX: dtmax_q = val;
            default: ;
        endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    static function longint unsigned clip(longint unsigned x, longint unsigned cap);
        return x > cap ? cap : x;
    endfunction

    function longint unsigned axis_step(longint unsigned w, longint unsigned s);
        if (s == 0) return dtmax_q;
        return clip((cfl_q * w) / s, STEP_CAP);
    endfunction

    function void note_cell(logic [31:0] rho_b, logic [31:0] mx_b, logic [31:0] my_b,
                            logic [31:0] e_b, bit last);
        longint rho, mx, my, en, internal;
        longint unsigned r, amx, amy, au, av, kin, gm1, pres, a2, a, sx, sy, dt, tx, ty;
        rho = longint'($signed(rho_b));
        mx  = longint'($signed(mx_b));
        my  = longint'($signed(my_b));
        en  = longint'($signed(e_b));
        if (rho <= 0) begin
            bad_seen = 1;
        end else begin
            r   = rho;
            amx = mx < 0 ? -mx : mx;
            amy = my < 0 ? -my : my;
            au  = clip((amx << FB) / r, SPEED_CAP);
            av  = clip((amy << FB) / r, SPEED_CAP);
            kin = (amx * amx + amy * amy) / (2 * r);
            internal = en - longint'(kin);
            gm1 = gamma_q >= (64'd1 << FB) ? gamma_q - (64'd1 << FB) : 0;
            pres = 0;
            if (internal > 0) pres = (gm1 * longint'(internal)) >> FB;
            // product may wrap past 64 bits, as the hardware width does
            a2 = clip((gamma_q * pres) / r, 64'hFFFF_FFFF_FFFF_FFFF >> FB);
            a  = int_sqrt(a2 << FB);
            sx = clip(a + au, SPEED_CAP);
            sy = clip(a + av, SPEED_CAP);
            if (sx > peak_sx) peak_sx = sx;
            if (sy > peak_sy) peak_sy = sy;
        end
        if (!last) return;
        dt = dtmax_q;
        tx = axis_step(dx_q, peak_sx);
        ty = axis_step(dy_q, peak_sy);
        if (tx < dt) dt = tx;
        if (ty < dt) dt = ty;
        step_q.push_back(dt[30:0]);
        flag_q.push_back(bad_seen);
        peak_sx  = 0;
        peak_sy  = 0;
        bad_seen = 0;
    endfunction

    function void check_result(logic [31:0] tdata, logic tuser);
        bit [30:0] exp_step;
        bit        exp_flag;
        if (step_q.size() == 0) begin
            $error("unexpected result transaction: timestep %0d", tdata[30:0]);
            errors++;
            return;
        end
        exp_step = step_q.pop_front();
        exp_flag = flag_q.pop_front();
        if (tdata[30:0] !== exp_step) begin
            $error("timestep: expected %0d, got %0d", exp_step, tdata[30:0]);
            errors++;
        end
        if (tuser !== exp_flag) begin
            $error("bad_cell_seen: expected %0d, got %0d", exp_flag, tuser);
            errors++;
        end
    endfunction

    function int pending();
        return step_q.size();
    endfunction
endclass

module tb;
    import cflr_pkg::*;

    localparam longint CYCLE_LIMIT = 3_000_000;

    logic aclk, aresetn;
    logic [127:0] s_tdata;
    logic s_tlast, s_tvalid, s_tready;
    logic [31:0] m_tdata;
    logic m_tuser, m_tvalid, m_tready;
    logic cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [WIDTH_W-1:0] cfg_wdata;

    cfl_timestep_board board = new();
    longint cycles = 0;
    int sent = 0;
    int stall_left = 0;

    cfl_timestep_reduction_top i_dut (.*);

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);

    // receiver back-pressure: mostly short stalls, occasional long ones
    always @(negedge aclk) begin
        int pick;
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 0;
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) m_tready <= 1;
            else if (pick < 95) begin stall_left = $urandom_range(0, 3); m_tready <= 0; end
            else begin stall_left = $urandom_range(20, 300); m_tready <= 0; end
        end
    end

    task automatic idle_gap();
        int pick, n;
        pick = $urandom_range(0, 99);
        n = pick < 65 ? 0 : (pick < 95 ? $urandom_range(1, 3) : $urandom_range(10, 80));
        if (n > 0) begin
            s_tvalid <= 0;
            repeat (n) @(negedge aclk);
        end
    endtask

    // valid stays up after acceptance until the next cell, a gap or a drain replaces it
    task automatic send_cell(logic [31:0] rho, logic [31:0] mx, logic [31:0] my,
                             logic [31:0] e, bit last);
        idle_gap();
        s_tdata  <= {e, my, mx, rho};
        s_tlast  <= last;
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_cell(rho, mx, my, e, last);
        sent++;
        @(negedge aclk);
    endtask

    // registers only change once the block has drained
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [30:0] val);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 0;
        board.write_reg(idx, val);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (board.pending() != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
    endtask

    task automatic random_cell(bit last);
        int mode;
        logic [31:0] rho, mx, my, e;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            rho = $urandom; mx = $urandom; my = $urandom; e = $urandom;
        end else if (mode == 1) begin
            rho = -$urandom_range(0, 1000); mx = $urandom; my = $urandom; e = $urandom;
        end else begin
            rho = $urandom_range(1 << 10, 1 << 24);
            mx  = $signed($urandom) >>> $urandom_range(0, 14);
            my  = $signed($urandom) >>> $urandom_range(0, 14);
            e   = mode == 2 ? $signed($urandom) >>> $urandom_range(0, 8)
                            : $urandom_range(0, 32'h7FFF_FFFF) >> $urandom_range(0, 10);
        end
        send_cell(rho, mx, my, e, last);
    endtask

    task automatic random_settings(int kind);
        if (kind == 0) begin
            write_reg(REG_GAMMA, 65537);  write_reg(REG_CFL, 65536);
            write_reg(REG_DX, 31'h7FFF_FFFF); write_reg(REG_DY, 1);
            write_reg(REG_DTMAX, 31'h7FFF_FFFF);
        end else if (kind == 1) begin
            write_reg(REG_GAMMA, 262144); write_reg(REG_CFL, 0);
            write_reg(REG_DX, 1); write_reg(REG_DY, 31'h7FFF_FFFF);
            write_reg(REG_DTMAX, 1);
        end else begin
            write_reg(REG_GAMMA, $urandom_range(65537, 262144));
            write_reg(REG_CFL, $urandom_range(0, 65536));
            write_reg(REG_DX, $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 14));
            write_reg(REG_DY, $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 14));
            write_reg(REG_DTMAX, $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 12));
        end
    endtask

    initial begin
        int len, kind;
        aresetn = 0; s_tvalid = 0; s_tlast = 0; s_tdata = '0;
        cfg_wr_en = 0; cfg_index = '0; cfg_wdata = '0; m_tready = 0;
        repeat (10) @(negedge aclk);
        aresetn = 1;

        // directed: reset settings first
        send_cell(32'h0001_0000, 32'h0002_0000, 32'hFFFE_0000, 32'h0010_0000, 1);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_cell(32'h0000_0001, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1);
        send_cell(32'h0000_0000, 32'h0, 32'h0, 32'h0, 1);
        send_cell(32'h8000_0000, 32'h1234, 32'h0, 32'h100, 0);
        send_cell(32'h0001_0000, 32'h0, 32'h0, 32'h0, 1);
        // negative internal energy clamps the pressure
        send_cell(32'h0001_0000, 32'h0010_0000, 32'h0, 32'h0000_0100, 1);
        drain();
        // gamma below one, unused indexes ignored
        write_reg(REG_GAMMA, 0);
        write_reg(3'd5, 31'h1234_5678);
        write_reg(3'd6, 31'h7FFF_FFFF);
        write_reg(3'd7, 0);
        write_reg(REG_DX, 0);
        send_cell(32'h0002_0000, 32'h0, 32'h0, 32'h0100_0000, 1);
        send_cell(32'h0001_0000, 32'h0003_0000, 32'h0001_0000, 32'h0100_0000, 1);
        drain();
        write_reg(REG_GAMMA, 31'h7FFFF);
        write_reg(REG_CFL, 31'h1FFFF);
        write_reg(REG_DY, 0);
        send_cell(32'h0000_0010, 32'h0, 32'h0, 32'h7FFF_FFFF, 1);
        drain();
        random_settings(0);
        send_cell(32'h0000_0001, 32'h0, 32'h0, 32'h0, 1);
        send_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        drain();
        random_settings(1);
        send_cell(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0100_0000, 1);
        drain();

        kind = 2;
        while (sent < 820) begin
            random_settings(kind);
            kind = $urandom_range(0, 9) < 2 ? $urandom_range(0, 1) : 2;
            repeat ($urandom_range(3, 10)) begin
                len = $urandom_range(0, 9) == 0 ? $urandom_range(10, 25) : $urandom_range(1, 6);
                for (int i = 0; i < len; i++) random_cell(i == len - 1);
            end
            drain();
        end

        while (board.pending() != 0) @(negedge aclk);
        repeat (700) @(negedge aclk);
        if (board.errors == 0) $display("All tests passed");
        else $display("Some tests failed");
        $finish;
    end
endmodule
